// ----- rtl/core/rotating_xor_byte_cipher_defines.svh -----
`ifndef ROTATING_XOR_BYTE_CIPHER_DEFINES_SVH
`define ROTATING_XOR_BYTE_CIPHER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define RXC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define RXC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/rxc_pkg.sv -----
`timescale 1ns / 1ps

package rxc_pkg;

  localparam int unsigned MAX_KEY_BYTES = 8;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned APB_ADDR_W    = 5;
  localparam int unsigned APB_DATA_W    = 64;

  localparam logic [7:0] ESC_LEAD  = 8'hC0;
  localparam logic [7:0] ESC_TRAIL = 8'h80;

  // Register indexes, decoded from paddr[4:3]
  localparam logic [1:0] REG_KEY_BYTES    = 2'd0;
  localparam logic [1:0] REG_KEY_LENGTH   = 2'd1;
  localparam logic [1:0] REG_CIPHER_MODE  = 2'd2;
  localparam logic [1:0] REG_DECRYPT_MODE = 2'd3;

  typedef enum logic [1:0] {
    MODE_NAIVE     = 2'd0,
    MODE_SINGLE    = 2'd1,
    MODE_USUAL     = 2'd2,
    MODE_ALTERNATE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    mode_t       cipher_mode;
    logic        decrypt_mode;
  } cfg_t;

  // One queued job: up to two cipher operations with their key bytes.
  typedef struct packed {
    logic       decrypt;
    mode_t      mode;
    logic [7:0] op0_byte;
    logic [7:0] op0_key;
    logic       op0_last;
    logic       op1_valid;
    logic [7:0] op1_byte;
    logic [7:0] op1_key;
    logic       op1_last;
  } job_t;

  function automatic logic [7:0] rot_right(input logic [7:0] v, input logic [2:0] r);
    logic [15:0] w;
    w = {v, v} >> r;
    return w[7:0];
  endfunction

  function automatic logic [7:0] rot_left(input logic [7:0] v, input logic [2:0] r);
    logic [15:0] w;
    w = {v, v} << r;
    return w[15:8];
  endfunction

  function automatic logic [7:0] encode_byte(input logic [7:0] c, input logic [7:0] k,
                                             input mode_t mode);
    logic [7:0] res;
    case (mode)
      MODE_SINGLE:    res = rot_right(c, k[2:0]) ^ k;
      MODE_USUAL:     res = rot_right(c ^ k, k[2:0]);
      MODE_ALTERNATE: res = k[0] ? rot_left(c ^ k, k[2:0]) : rot_right(c ^ k, k[2:0]);
      default:        res = c ^ k;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] decode_byte(input logic [7:0] c, input logic [7:0] k,
                                             input mode_t mode);
    logic [7:0] res;
    case (mode)
      MODE_SINGLE:    res = rot_left(c ^ k, k[2:0]);
      MODE_USUAL:     res = rot_left(c, k[2:0]) ^ k;
      MODE_ALTERNATE: res = k[0] ? (rot_right(c, k[2:0]) ^ k) : (rot_left(c, k[2:0]) ^ k);
      default:        res = c ^ k;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/core/rxc_cfg.sv -----
`timescale 1ns / 1ps

module rxc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rxc_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [rxc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [rxc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output rxc_pkg::cfg_t                       cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:3];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_bytes    <= '0;
      cfg.key_length   <= 4'd1;
      cfg.cipher_mode  <= rxc_pkg::MODE_NAIVE;
      cfg.decrypt_mode <= 1'b0;
    end else if (wr_en) begin
      case (reg_index)
        rxc_pkg::REG_KEY_BYTES:    cfg.key_bytes    <= pwdata;
        rxc_pkg::REG_KEY_LENGTH:   cfg.key_length   <= pwdata[3:0];
        rxc_pkg::REG_CIPHER_MODE:  cfg.cipher_mode  <= rxc_pkg::mode_t'(pwdata[1:0]);
        rxc_pkg::REG_DECRYPT_MODE: cfg.decrypt_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      rxc_pkg::REG_KEY_BYTES:    prdata = cfg.key_bytes;
      rxc_pkg::REG_KEY_LENGTH:   prdata = {60'd0, cfg.key_length};
      rxc_pkg::REG_CIPHER_MODE:  prdata = {62'd0, cfg.cipher_mode};
      rxc_pkg::REG_DECRYPT_MODE: prdata = {63'd0, cfg.decrypt_mode};
      default:                   prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/rxc_front.sv -----
`timescale 1ns / 1ps

module rxc_front #(
  parameter int unsigned MAX_KEY_BYTES = rxc_pkg::MAX_KEY_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  rxc_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  rxc_pkg::in_item_t in_data,
  input  logic              queue_full,
  output logic              push,
  output rxc_pkg::job_t     job
);

  localparam logic [3:0] MaxLen = 4'(MAX_KEY_BYTES);

  logic [2:0] key_position;
  logic [2:0] key_position_next;
  logic       held;
  logic       held_next;
  logic [3:0] len;
  logic [2:0] pos0;
  logic [2:0] pos1;
  logic [2:0] pos2;
  logic [7:0] key0;
  logic [7:0] key1;
  logic       fire;
  logic       has_job;
  logic       lead_open;
  logic [7:0] b;
  logic       last;

  function automatic logic [2:0] next_pos(input logic [2:0] p, input logic [3:0] l);
    logic [3:0] inc;
    inc = {1'b0, p} + 4'd1;
    return (inc >= l) ? 3'd0 : inc[2:0];
  endfunction

  assign b    = in_data.in_byte;
  assign last = in_data.in_last;

  always_comb begin
    if (cfg.key_length == 4'd0) begin
      len = 4'd1;
    end else if (cfg.key_length > MaxLen) begin
      len = MaxLen;
    end else begin
      len = cfg.key_length;
    end
  end

  assign pos0 = ({1'b0, key_position} >= len) ? 3'd0 : key_position;
  assign pos1 = next_pos(pos0, len);
  assign pos2 = next_pos(pos1, len);
  assign key0 = cfg.key_bytes[{pos0, 3'b000} +: 8];
  assign key1 = cfg.key_bytes[{pos1, 3'b000} +: 8];

  assign in_ready  = !queue_full;
  assign fire      = in_valid && in_ready;
  assign lead_open = (b == rxc_pkg::ESC_LEAD) && !last;
  assign push      = fire && has_job;

  always_comb begin
    has_job           = 1'b1;
    held_next         = held;
    key_position_next = key_position;
    job.decrypt       = cfg.decrypt_mode;
    job.mode          = cfg.cipher_mode;
    job.op0_byte      = b;
    job.op0_key       = key0;
    job.op0_last      = last;
    job.op1_valid     = 1'b0;
    job.op1_byte      = b;
    job.op1_key       = key1;
    job.op1_last      = last;
    if (!cfg.decrypt_mode) begin
      held_next         = 1'b0;
      key_position_next = last ? 3'd0 : pos1;
    end else if (held) begin
      held_next = 1'b0;
      if (b == rxc_pkg::ESC_TRAIL) begin
        job.op0_byte      = 8'd0;
        key_position_next = last ? 3'd0 : pos1;
      end else begin
        // decode the held lead on its own, then the new byte unless it opens a new lead
        job.op0_byte = rxc_pkg::ESC_LEAD;
        job.op0_last = 1'b0;
        if (lead_open) begin
          held_next         = 1'b1;
          key_position_next = pos1;
        end else begin
          job.op1_valid     = 1'b1;
          key_position_next = last ? 3'd0 : pos2;
        end
      end
    end else if (lead_open) begin
      has_job   = 1'b0;
      held_next = 1'b1;
    end else begin
      key_position_next = last ? 3'd0 : pos1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
      held         <= 1'b0;
    end else if (fire) begin
      key_position <= key_position_next;
      held         <= held_next;
    end
  end

endmodule

// ----- rtl/core/rxc_queue.sv -----
`timescale 1ns / 1ps

`include "rotating_xor_byte_cipher_defines.svh"

module rxc_queue #(
  parameter int unsigned DEPTH = rxc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  rxc_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output rxc_pkg::job_t rd_job,
  output logic          empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);

  rxc_pkg::job_t   slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full   = (count == FullCount);
  assign empty  = (count == '0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `RXC_ASSERT(a_no_overflow, clk, rst, wr_en |-> !full, "job written into a full queue")
  `RXC_ASSERT(a_no_underflow, clk, rst, rd_en |-> !empty, "job read from an empty queue")
  `RXC_ASSERT_ALWAYS(a_count_bound, clk, rst || (count <= FullCount), "queue count beyond depth")

endmodule

// ----- rtl/core/rxc_back.sv -----
`timescale 1ns / 1ps

`include "rotating_xor_byte_cipher_defines.svh"

module rxc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  rxc_pkg::job_t      job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output rxc_pkg::out_item_t out_data
);

  logic       phase;
  logic       load;
  logic       final_out;
  logic [7:0] enc0;
  logic [7:0] dec0;
  logic [7:0] dec1;
  rxc_pkg::out_item_t next_item;

  assign enc0 = rxc_pkg::encode_byte(job.op0_byte, job.op0_key, job.mode);
  assign dec0 = rxc_pkg::decode_byte(job.op0_byte, job.op0_key, job.mode);
  assign dec1 = rxc_pkg::decode_byte(job.op1_byte, job.op1_key, job.mode);

  always_comb begin
    if (!job.decrypt) begin
      if (enc0 == 8'd0) begin
        // escape a zero cipher byte as lead then trail
        next_item.out_byte = phase ? rxc_pkg::ESC_TRAIL : rxc_pkg::ESC_LEAD;
        next_item.out_last = phase && job.op0_last;
        final_out          = phase;
      end else begin
        next_item.out_byte = enc0;
        next_item.out_last = job.op0_last;
        final_out          = 1'b1;
      end
    end else begin
      next_item.out_byte = phase ? dec1 : dec0;
      next_item.out_last = phase ? job.op1_last : job.op0_last;
      final_out          = phase || !job.op1_valid;
    end
  end

  assign load = job_valid && (!out_valid || out_ready);
  assign pop  = load && final_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        phase     <= !final_out;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= next_item;
    end
  end

  `RXC_ASSERT(a_phase_has_job, clk, rst, phase |-> job_valid, "second output with no job")
  `RXC_ASSERT(a_phase_decrypt_op1, clk, rst, (phase && job.decrypt) |-> job.op1_valid,
              "second decrypt output without a second operation")

endmodule

// ----- rtl/core/rotating_xor_byte_cipher.sv -----
`timescale 1ns / 1ps

// Repeating-key byte cipher with null escape on encrypt and unescape on decrypt.
// Input channel in_valid/in_ready/in_data carries one byte and its last flag;
// output channel out_valid/out_ready/out_data carries result bytes in order.
// Configure through the APB port (registers at 0x00 key bytes, 0x08 key length,
// 0x10 cipher mode, 0x18 decrypt mode) only while no message is in flight.
// A byte accepted at the input is written into the job queue, then loaded into
// the registered output stage, which raises out_valid.
// Throughput: one byte per cycle while the job queue has room. An item with two
// results (escaped zero on encrypt, held lead that turns out unpaired on decrypt)
// takes two output transfers; a four-entry job queue between the key sequencer
// and the cipher stage absorbs that, so input stalls only once the queue fills.
// A lead byte held on decrypt gives no result until its follower arrives.
// Reset (synchronous, rst high) empties the queue and output stage, sets key
// position to zero, drops any held lead and restores register defaults.
// When the receiver stalls, the output stage holds its transfer, the queue
// fills, and in_ready falls once the queue is full.
module rotating_xor_byte_cipher #(
  parameter int unsigned MAX_KEY_BYTES = rxc_pkg::MAX_KEY_BYTES,
  parameter int unsigned QUEUE_DEPTH   = rxc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rxc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rxc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rxc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rxc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rxc_pkg::out_item_t             out_data
);

  rxc_pkg::cfg_t cfg;
  rxc_pkg::job_t wr_job;
  rxc_pkg::job_t rd_job;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  rxc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rxc_front #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (full),
    .push       (push),
    .job        (wr_job)
  );

  rxc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_job (wr_job),
    .full   (full),
    .rd_en  (pop),
    .rd_job (rd_job),
    .empty  (empty)
  );

  rxc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!empty),
    .job       (rd_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
